@@ rtl/qsds_pkg.sv @@
// Shared constants and types of the quicksort descending sorter.
package qsds_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 16;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int RANGE_W    = 2 * IDX_W;
  localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_POP,
    ST_POPW,
    ST_PIV,
    ST_NEXT,
    ST_CMP,
    ST_SWP,
    ST_SWP2,
    ST_FIN,
    ST_FIN2,
    ST_PUSH1,
    ST_PUSH2,
    ST_OUT_LD,
    ST_OUT_HOLD
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctrl_t;

endpackage

@@ rtl/qsds_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module qsds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/qsds_stack.sv @@
// Range stack: pointer management around a RAM of pending sort ranges.
module qsds_stack (
  input  logic                         clk,
  input  logic                         rst_n,
  input  qsds_pkg::stk_ctrl_t          ctrl,
  input  logic [qsds_pkg::RANGE_W-1:0] push_data,
  output logic [qsds_pkg::RANGE_W-1:0] pop_data,
  output logic                         empty
);

  logic [qsds_pkg::CNT_W-1:0] sp_r;
  logic [qsds_pkg::CNT_W-1:0] sp_nxt;
  logic [qsds_pkg::CNT_W-1:0] sp_dec;
  logic                       full;
  logic                       we;

  assign sp_dec = sp_r - qsds_pkg::CNT_W'(1);
  assign full   = (sp_r == qsds_pkg::CNT_W'(qsds_pkg::DEPTH));
  assign empty  = (sp_r == '0);
  assign we     = ctrl.push && !full;

  always_comb begin
    sp_nxt = sp_r;
    if (ctrl.clear) begin
      sp_nxt = '0;
    end else if (we) begin
      sp_nxt = sp_r + qsds_pkg::CNT_W'(1);
    end else if (ctrl.pop && !empty) begin
      sp_nxt = sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  qsds_ram #(
    .WIDTH(qsds_pkg::RANGE_W),
    .DEPTH(qsds_pkg::DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (we),
    .waddr(sp_r[qsds_pkg::IDX_W-1:0]),
    .wdata(push_data),
    .raddr(sp_dec[qsds_pkg::IDX_W-1:0]),
    .rdata(pop_data)
  );

endmodule

@@ rtl/quicksort_descending_sorter_core.sv @@
// Loading takes one request per cycle; the sort starts after the request marked last.
// Each partition step reads its compared elements one by one through the single read
// port of the element RAM, and each swap adds the write states ST_SWP and ST_SWP2.
// Sorted results leave one at a time after the sort, each held until out_tready takes it.
// Synchronous active-low reset empties the set and the range stack.
module quicksort_descending_sorter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [qsds_pkg::TDATA_W-1:0]  in_tdata,   // [15:0] value
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [qsds_pkg::TDATA_W-1:0]  out_tdata,  // [15:0] sorted_value
  output logic                          out_tlast,
  output logic                          out_tuser   // [0] overflow
);

  localparam int IW = qsds_pkg::IDX_W;
  localparam int CW = qsds_pkg::CNT_W;
  localparam int DW = qsds_pkg::DATA_WIDTH;

  qsds_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [IW-1:0] lo_r, lo_nxt;
  logic [IW-1:0] hi_r, hi_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [DW-1:0] piv_r, piv_nxt;
  logic [DW-1:0] tmp_r, tmp_nxt;
  logic          oval_r, oval_nxt;
  logic [DW-1:0] odata_r, odata_nxt;
  logic          olast_r, olast_nxt;
  logic          oovf_r, oovf_nxt;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  qsds_pkg::stk_ctrl_t              stk_ctrl;
  logic [qsds_pkg::RANGE_W-1:0]     stk_push_data;
  logic [qsds_pkg::RANGE_W-1:0]     stk_pop_data;
  logic                             stk_empty;

  logic          in_acc;
  logic          out_acc;
  logic [CW-1:0] last_idx;
  logic [IW-1:0] pop_lo;
  logic [IW-1:0] pop_hi;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign last_idx = count_r - CW'(1);
  assign pop_lo   = stk_pop_data[IW-1:0];
  assign pop_hi   = stk_pop_data[2*IW-1:IW];

  assign in_tready  = (state_r == qsds_pkg::ST_LOAD);
  assign out_tvalid = oval_r;
  assign out_tdata  = qsds_pkg::TDATA_W'(odata_r);
  assign out_tlast  = olast_r;
  assign out_tuser  = oovf_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    j_nxt         = j_r;
    slot_nxt      = slot_r;
    k_nxt         = k_r;
    piv_nxt       = piv_r;
    tmp_nxt       = tmp_r;
    oval_nxt      = oval_r;
    odata_nxt     = odata_r;
    olast_nxt     = olast_r;
    oovf_nxt      = oovf_r;
    mem_we        = 1'b0;
    mem_waddr     = slot_r;
    mem_wdata     = tmp_r;
    mem_raddr     = j_r;
    stk_ctrl      = '0;
    stk_push_data = {hi_r, lo_r};

    unique case (state_r)
      qsds_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (count_r < CW'(qsds_pkg::DEPTH)) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[IW-1:0];
            mem_wdata = in_tdata[DW-1:0];
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = qsds_pkg::ST_INIT;
          end
        end
      end

      qsds_pkg::ST_INIT: begin
        stk_ctrl.clear = 1'b1;
        if (count_r >= CW'(2)) begin
          stk_ctrl.clear = 1'b0;
          stk_ctrl.push  = 1'b1;
          stk_push_data  = {last_idx[IW-1:0], IW'(0)};
        end
        state_nxt = qsds_pkg::ST_POP;
      end

      qsds_pkg::ST_POP: begin
        if (stk_empty) begin
          mem_raddr = '0;
          k_nxt     = '0;
          state_nxt = qsds_pkg::ST_OUT_LD;
        end else begin
          stk_ctrl.pop = 1'b1;
          state_nxt    = qsds_pkg::ST_POPW;
        end
      end

      qsds_pkg::ST_POPW: begin
        lo_nxt    = pop_lo;
        hi_nxt    = pop_hi;
        j_nxt     = pop_lo;
        slot_nxt  = pop_lo;
        mem_raddr = pop_hi;
        if (pop_lo >= pop_hi) begin
          state_nxt = qsds_pkg::ST_POP;
        end else begin
          state_nxt = qsds_pkg::ST_PIV;
        end
      end

      qsds_pkg::ST_PIV: begin
        piv_nxt   = mem_rdata;
        state_nxt = qsds_pkg::ST_NEXT;
      end

      // Reads the next candidate, or the front-part boundary once the scan is done.
      qsds_pkg::ST_NEXT: begin
        if (j_r < hi_r) begin
          mem_raddr = j_r;
          state_nxt = qsds_pkg::ST_CMP;
        end else begin
          mem_raddr = slot_r;
          state_nxt = qsds_pkg::ST_FIN;
        end
      end

      qsds_pkg::ST_CMP: begin
        if ($signed(mem_rdata) >= $signed(piv_r)) begin
          if (slot_r == j_r) begin
            slot_nxt  = slot_r + IW'(1);
            j_nxt     = j_r + IW'(1);
            state_nxt = qsds_pkg::ST_NEXT;
          end else begin
            tmp_nxt   = mem_rdata;
            mem_raddr = slot_r;
            state_nxt = qsds_pkg::ST_SWP;
          end
        end else begin
          j_nxt     = j_r + IW'(1);
          state_nxt = qsds_pkg::ST_NEXT;
        end
      end

      qsds_pkg::ST_SWP: begin
        mem_we    = 1'b1;
        mem_waddr = slot_r;
        mem_wdata = tmp_r;
        tmp_nxt   = mem_rdata;
        state_nxt = qsds_pkg::ST_SWP2;
      end

      qsds_pkg::ST_SWP2: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = tmp_r;
        slot_nxt  = slot_r + IW'(1);
        j_nxt     = j_r + IW'(1);
        state_nxt = qsds_pkg::ST_NEXT;
      end

      qsds_pkg::ST_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = slot_r;
        mem_wdata = piv_r;
        tmp_nxt   = mem_rdata;
        state_nxt = qsds_pkg::ST_FIN2;
      end

      qsds_pkg::ST_FIN2: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = tmp_r;
        state_nxt = qsds_pkg::ST_PUSH1;
      end

      qsds_pkg::ST_PUSH1: begin
        if (CW'(slot_r) > CW'(lo_r) + CW'(1)) begin
          stk_ctrl.push = 1'b1;
          stk_push_data = {slot_r - IW'(1), lo_r};
        end
        state_nxt = qsds_pkg::ST_PUSH2;
      end

      qsds_pkg::ST_PUSH2: begin
        if (CW'(slot_r) + CW'(1) < CW'(hi_r)) begin
          stk_ctrl.push = 1'b1;
          stk_push_data = {hi_r, slot_r + IW'(1)};
        end
        state_nxt = qsds_pkg::ST_POP;
      end

      qsds_pkg::ST_OUT_LD: begin
        oval_nxt  = 1'b1;
        odata_nxt = mem_rdata;
        olast_nxt = (CW'(k_r) == last_idx);
        oovf_nxt  = ovf_r;
        state_nxt = qsds_pkg::ST_OUT_HOLD;
      end

      qsds_pkg::ST_OUT_HOLD: begin
        if (out_acc) begin
          oval_nxt = 1'b0;
          if (olast_r) begin
            count_nxt      = '0;
            ovf_nxt        = 1'b0;
            stk_ctrl.clear = 1'b1;
            state_nxt      = qsds_pkg::ST_LOAD;
          end else begin
            k_nxt     = k_r + IW'(1);
            mem_raddr = k_r + IW'(1);
            state_nxt = qsds_pkg::ST_OUT_LD;
          end
        end
      end

      default: begin
        state_nxt = qsds_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qsds_pkg::ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    j_r     <= j_nxt;
    slot_r  <= slot_nxt;
    k_r     <= k_nxt;
    piv_r   <= piv_nxt;
    tmp_r   <= tmp_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
  end

  qsds_ram #(
    .WIDTH(qsds_pkg::DATA_WIDTH),
    .DEPTH(qsds_pkg::DEPTH)
  ) u_elem_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  qsds_stack u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (stk_ctrl),
    .push_data(stk_push_data),
    .pop_data (stk_pop_data),
    .empty    (stk_empty)
  );

endmodule
